[design/dqts_pkg.sv]
// ----------------------------------------------------------------------------
// dqts_pkg
// Types and codes shared by the delta-queue scheduler core, its cells and
// its checker.
// ----------------------------------------------------------------------------
package dqts_pkg;

  // Request kinds
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
  } dqts_req_t;

  typedef struct packed {
    logic       ran_valid;
    logic [7:0] ran_task;
    logic       add_dropped;
  } dqts_res_t;

  // One list entry held by a cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  task_id;
    logic [15:0] delta;
    logic [15:0] period;
  } dqts_entry_t;

  // Insertion word travelling down the chain. In seek mode delay is the
  // remaining delay of the new task; in shift mode the word carries a
  // displaced entry and delay is that entry's delta.
  typedef struct packed {
    logic        active;
    logic        shift;
    logic [7:0]  task_id;
    logic [15:0] delay;
    logic [15:0] period;
  } dqts_tok_t;

  // Broadcast commands to the cells
  typedef struct packed {
    logic pop;
    logic tick;
  } dqts_cmd_t;

endpackage

[design/dqts_cell.sv]
// ----------------------------------------------------------------------------
// dqts_cell
// One slot of the delta list: holds an entry, takes part in the insertion
// walk and shifts towards the head on a pop.
// ----------------------------------------------------------------------------
module dqts_cell (
  input  logic                clk,
  input  logic                rst,
  input  dqts_pkg::dqts_cmd_t cmd,
  input  dqts_pkg::dqts_tok_t tok_in,
  input  dqts_pkg::dqts_entry_t nb_in,
  output dqts_pkg::dqts_tok_t tok_out,
  output dqts_pkg::dqts_entry_t ent,
  output logic                seek_store
);
  import dqts_pkg::*;

  dqts_entry_t ent_next;
  dqts_tok_t   tok_next;
  logic        fits;

  // New task settles here when the slot is free or its delay runs out first
  assign fits       = !ent.valid || (tok_in.delay < ent.delta);
  assign seek_store = tok_in.active && !tok_in.shift && fits;

  always_comb begin
    ent_next = ent;
    tok_next = '0;
    if (cmd.pop) begin
      ent_next = nb_in;
    end else if (cmd.tick) begin
      if (ent.valid && ent.delta != 16'd0) begin
        ent_next.delta = ent.delta - 16'd1;
      end
    end else if (tok_in.active) begin
      if (!ent.valid) begin
        ent_next.valid   = 1'b1;
        ent_next.task_id = tok_in.task_id;
        ent_next.delta   = tok_in.delay;
        ent_next.period  = tok_in.period;
      end else if (!tok_in.shift && !fits) begin
        // advance past this entry, consuming its delta
        tok_next        = tok_in;
        tok_next.delay  = tok_in.delay - ent.delta;
      end else begin
        ent_next.task_id = tok_in.task_id;
        ent_next.delta   = tok_in.delay;
        ent_next.period  = tok_in.period;
        tok_next.active  = 1'b1;
        tok_next.shift   = 1'b1;
        tok_next.task_id = ent.task_id;
        tok_next.period  = ent.period;
        // the successor of a fresh insert loses the new task's delay
        tok_next.delay   = tok_in.shift ? ent.delta : (ent.delta - tok_in.delay);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent     <= '0;
      tok_out <= '0;
    end else begin
      ent     <= ent_next;
      tok_out <= tok_next;
    end
  end

endmodule

[design/delta_queue_task_scheduler_core.sv]
// ----------------------------------------------------------------------------
// delta_queue_task_scheduler_core
// Delta-list cooperative task scheduler built as a chain of list cells.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Word        Notes
//  --------  -----------------  ----------  ------------------------------
//  request   start && !busy     dqts_req_t  tick, add or dispatch
//  result    done (one cycle)   dqts_res_t  one word per request
//
// Tick, unused kind, add to a full list and dispatch that does not
// re-add give their result in the cycle after acceptance and never raise
// busy. An add, or a dispatch of a periodic task, sends an insertion word
// down the cell chain one cell a cycle up to the first free cell; busy stays
// high for the whole walk, and done ends the walk.
// Reset (synchronous, rst high) empties the list.
// The receiver cannot stall: each result word is shown once, for one cycle.
//
module delta_queue_task_scheduler_core #(
  parameter int MAX_TASKS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dqts_pkg::dqts_req_t request,
  output logic                done,
  output dqts_pkg::dqts_res_t result
);
  import dqts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t      state, state_next;
  dqts_tok_t   tok0, tok0_next;
  logic        head_ready, head_ready_next;
  logic        done_next;
  dqts_res_t   result_next;
  dqts_res_t   pend, pend_next;

  dqts_cmd_t   cell_cmd [MAX_TASKS];
  dqts_tok_t   cell_tin [MAX_TASKS];
  dqts_tok_t   cell_tok [MAX_TASKS];
  dqts_entry_t cell_nb  [MAX_TASKS];
  dqts_entry_t cell_ent [MAX_TASKS];
  logic [MAX_TASKS-1:0] cell_seek;
  logic [MAX_TASKS-1:0] tok_act;

  logic accept;
  logic do_pop;
  logic do_tick;

  assign busy   = (state == ST_WALK);
  assign accept = start && (state == ST_IDLE);

  // ---- cell chain: insertion words move tailwards, pops move headwards ----
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    assign cell_cmd[i].pop  = do_pop;
    assign cell_cmd[i].tick = do_tick && (i == 0);
    if (i == 0) begin : g_head
      assign cell_tin[i] = tok0;
    end else begin : g_body
      assign cell_tin[i] = cell_tok[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_tail
      assign cell_nb[i] = '0;
    end else begin : g_inner
      assign cell_nb[i] = cell_ent[i+1];
    end
    assign tok_act[i] = cell_tok[i].active;

    dqts_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd[i]),
      .tok_in     (cell_tin[i]),
      .nb_in      (cell_nb[i]),
      .tok_out    (cell_tok[i]),
      .ent        (cell_ent[i]),
      .seek_store (cell_seek[i])
    );
  end

  // ---- control ----
  always_comb begin
    state_next      = state;
    tok0_next       = '0;
    head_ready_next = head_ready;
    done_next       = 1'b0;
    result_next     = result;
    pend_next       = pend;
    do_pop          = 1'b0;
    do_tick         = 1'b0;

    if (accept) begin
      case (request.kind)
        KIND_TICK: begin
          // count the head down, or mark it ready once it hits zero
          do_tick = 1'b1;
          if (cell_ent[0].valid && cell_ent[0].delta == 16'd0) begin
            head_ready_next = 1'b1;
          end
          done_next   = 1'b1;
          result_next = '0;
        end
        KIND_ADD: begin
          if (cell_ent[MAX_TASKS-1].valid) begin
            // list full: drop the request
            done_next               = 1'b1;
            result_next             = '0;
            result_next.add_dropped = 1'b1;
          end else begin
            tok0_next.active  = 1'b1;
            tok0_next.task_id = request.task_id;
            tok0_next.delay   = request.delay_ticks;
            tok0_next.period  = request.period_ticks;
            pend_next         = '0;
            state_next        = ST_WALK;
          end
        end
        KIND_DISPATCH: begin
          head_ready_next = 1'b0;
          result_next     = '0;
          if (head_ready && cell_ent[0].valid) begin
            do_pop             = 1'b1;
            pend_next          = '0;
            pend_next.ran_valid = 1'b1;
            pend_next.ran_task  = cell_ent[0].task_id;
            if (cell_ent[0].period != 16'd0) begin
              // re-add a periodic task with its period as delay
              tok0_next.active  = 1'b1;
              tok0_next.task_id = cell_ent[0].task_id;
              tok0_next.delay   = cell_ent[0].period;
              tok0_next.period  = cell_ent[0].period;
              state_next        = ST_WALK;
            end else begin
              done_next   = 1'b1;
              result_next = pend_next;
            end
          end else begin
            done_next = 1'b1;
          end
        end
        default: begin
          done_next   = 1'b1;
          result_next = '0;
        end
      endcase
    end else if (state == ST_WALK) begin
      // a new head loses any ready mark
      if (cell_seek[0]) begin
        head_ready_next = 1'b0;
      end
      if (!tok0.active && (tok_act == '0)) begin
        done_next   = 1'b1;
        result_next = pend;
        state_next  = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tok0       <= '0;
      head_ready <= 1'b0;
      done       <= 1'b0;
      result     <= '0;
      pend       <= '0;
    end else begin
      state      <= state_next;
      tok0       <= tok0_next;
      head_ready <= head_ready_next;
      done       <= done_next;
      result     <= result_next;
      pend       <= pend_next;
    end
  end

endmodule

[design/dqts_checker.sv]
// ----------------------------------------------------------------------------
// dqts_checker
// Port-level checks for the delta-queue scheduler core.
// ----------------------------------------------------------------------------
module dqts_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input dqts_pkg::dqts_req_t request,
  input logic                done,
  input dqts_pkg::dqts_res_t result
);
  import dqts_pkg::*;

  // a tick always completes in the next cycle
  a_tick_done : assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.kind == KIND_TICK |=> done)
    else $error("tick without result in next cycle");

  // the result strobe ends any walk
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // only an accepted request starts a walk
  a_busy_start : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // a result never both releases a task and drops one
  a_excl : assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.ran_valid && result.add_dropped))
    else $error("dispatch and drop in one result");

  // no task id without a release
  a_task_zero : assert property (@(posedge clk) disable iff (rst)
    done && !result.ran_valid |-> result.ran_task == 8'd0)
    else $error("task id reported without release");

endmodule

bind delta_queue_task_scheduler_core dqts_checker u_dqts_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delta-queue task scheduler core. Request words
// are driven through the start/busy handshake and mirrored into a behavioural
// copy of the delta list. Every result word is compared against the oldest
// expected word. Directed corner cases run first, then random traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import dqts_pkg::*;

  localparam int         MAX_TASKS     = 8;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = MAX_TASKS + 4;
  localparam int         DRAIN_LIMIT   = 2000;

  logic      clk     = 1'b0;
  logic      rst     = 1'b1;
  logic      start   = 1'b0;
  logic      busy;
  dqts_req_t request = '0;
  logic      done;
  dqts_res_t result;

  always #5 clk = ~clk;

  delta_queue_task_scheduler_core #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // Behavioural copy of the delta list; valid entries sit at 0 .. count-1.
  dqts_entry_t slot [MAX_TASKS];
  logic        head_due;

  // Result words still owed by the core, oldest first.
  dqts_res_t pending_results [$];

  int mismatches    = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int runs_seen     = 0;
  int drops_seen    = 0;
  int cycle_count   = 0;
  bit idle_enable   = 1'b1;

  // --------------------------------------------------------------------------
  // Delta-list predictor
  // --------------------------------------------------------------------------
  function automatic void clear_schedule();
    int k;
    for (k = 0; k < MAX_TASKS; k++) slot[k] = '0;
    head_due = 1'b0;
  endfunction

  function automatic int slot_count();
    int n;
    n = 0;
    while (n < MAX_TASKS && slot[n].valid) n++;
    return n;
  endfunction

  // Insert a task behind every entry due at the same tick; return 1 if the
  // list was full and the task is dropped.
  function automatic bit place_task(logic [7:0] id, logic [15:0] delay, logic [15:0] rep);
    int          n;
    int          pos;
    int          k;
    logic [15:0] rem;
    n   = slot_count();
    pos = 0;
    rem = delay;
    if (n >= MAX_TASKS) return 1'b1;
    // Walk the list, consuming deltas while the new task is due no earlier.
    while (pos < n && rem >= slot[pos].delta) begin
      rem = rem - slot[pos].delta;
      pos++;
    end
    // Charge the successor only with what is left after the new task.
    if (pos < n) slot[pos].delta = slot[pos].delta - rem;
    for (k = n; k > pos; k--) slot[k] = slot[k - 1];
    slot[pos].valid   = 1'b1;
    slot[pos].task_id = id;
    slot[pos].delta   = rem;
    slot[pos].period  = rep;
    // A new head has not yet been seen due by a tick.
    if (pos == 0) head_due = 1'b0;
    return 1'b0;
  endfunction

  function automatic void pop_front_slot();
    int k;
    for (k = 0; k + 1 < MAX_TASKS; k++) slot[k] = slot[k + 1];
    slot[MAX_TASKS - 1] = '0;
    head_due = 1'b0;
  endfunction

  // Advance the predictor by one accepted request and return its result word.
  function automatic dqts_res_t schedule_step(dqts_req_t w);
    dqts_res_t   res;
    logic [7:0]  id;
    logic [15:0] rep;
    res = '0;
    case (w.kind)
      KIND_TICK: begin
        // Count the head down, or hold it due once it reaches zero.
        if (slot[0].valid) begin
          if (slot[0].delta == 16'd0) head_due = 1'b1;
          else slot[0].delta = slot[0].delta - 16'd1;
        end
      end
      KIND_ADD: begin
        res.add_dropped = place_task(w.task_id, w.delay_ticks, w.period_ticks);
      end
      KIND_DISPATCH: begin
        if (head_due && slot[0].valid) begin
          id            = slot[0].task_id;
          rep           = slot[0].period;
          res.ran_valid = 1'b1;
          res.ran_task  = id;
          pop_front_slot();
          // Re-arm a periodic task; a slot was just freed so it always fits.
          if (rep != 16'd0) void'(place_task(id, rep, rep));
        end else begin
          head_due = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  function automatic dqts_req_t make_word(logic [1:0] kind, logic [7:0] id,
                                          logic [15:0] delay, logic [15:0] rep);
    dqts_req_t w;
    w.kind         = kind;
    w.task_id      = id;
    w.delay_ticks  = delay;
    w.period_ticks = rep;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a following word keeps it up without a glitch.
  task automatic send_word(input dqts_req_t w);
    int gap;
    if (idle_enable && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= w;
    // Hold the word until an edge sees busy low.
    do @(posedge clk); while (busy);
    pending_results.push_back(schedule_step(w));
    words_sent++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every done strobe must match the oldest expected word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    dqts_res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result word with nothing pending: ",
                    "valid=%0b task=%0d dropped=%0b"},
                   $realtime, result.ran_valid, result.ran_task, result.add_dropped);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (want.ran_valid) runs_seen++;
        if (want.add_dropped) drops_seen++;
        if (result.ran_valid !== want.ran_valid || result.ran_task !== want.ran_task ||
            result.add_dropped !== want.add_dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result word %0d: expected valid=%0b task=%0d dropped=%0b, ",
                      "got valid=%0b task=%0d dropped=%0b"},
                     $realtime, words_checked, want.ran_valid, want.ran_task,
                     want.add_dropped, result.ran_valid, result.ran_task,
                     result.add_dropped);
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d result words outstanding",
               pending_results.size());
      $display("** delta_queue_task_scheduler_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty list: tick and dispatch change nothing; the unused kind is ignored.
  task automatic test_idle_requests();
    send_word(make_word(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(KIND_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF));
  endtask

  // Insertion order, ready marking, one-shot and periodic dispatch.
  task automatic test_basic_flow();
    // Task id zero is an ordinary id
    send_word(make_word(KIND_ADD, 8'h00, 16'h0000, 16'h0000));
    // Append past the tail with the largest field values
    send_word(make_word(KIND_ADD, 8'hFF, 16'hFFFF, 16'hFFFF));
    // Equal due time: must land behind task zero
    send_word(make_word(KIND_ADD, 8'h01, 16'h0000, 16'h0003));
    send_word(make_word(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    // Ready head stays ready on a repeated tick
    send_word(make_word(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    // New head not yet seen due: no run
    send_word(make_word(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    // Periodic task runs and is re-armed with its period
    send_word(make_word(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
  endtask

  // Fill the list, then one more add must be dropped.
  task automatic test_full_list();
    int i;
    for (i = 0; i < 7; i++)
      send_word(make_word(KIND_ADD, 8'h10 + i[7:0], 16'(i), 16'h0000));
  endtask

  // Mostly well-formed traffic with small delays; wide mode opens every field.
  task automatic test_random_traffic(input int count, input bit wide);
    int          i;
    int          pick;
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [15:0] delay;
    logic [15:0] rep;
    for (i = 0; i < count; i++) begin
      pick  = $urandom_range(0, 99);
      id    = 8'($urandom_range(0, 255));
      delay = 16'($urandom_range(0, 65535));
      rep   = 16'($urandom_range(0, 65535));
      if (pick < 45) kind = KIND_TICK;
      else if (pick < 70) kind = KIND_ADD;
      else if (pick < 96) kind = KIND_DISPATCH;
      else kind = KIND_UNUSED;
      if (kind == KIND_ADD) begin
        // Keep most delays short so tasks fall due and the list churns.
        if (!wide && $urandom_range(0, 99) < 95) delay = 16'($urandom_range(0, 12));
        if ($urandom_range(0, 99) >= 12) rep = 16'h0000;
        else if (!wide) rep = 16'($urandom_range(1, 8));
      end
      send_word(make_word(kind, id, delay, rep));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    int waited;
    clear_schedule();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_basic_flow();
    test_full_list();
    // Back-to-back stretch, then random gaps again
    idle_enable = 1'b0;
    test_random_traffic(120, 1'b0);
    idle_enable = 1'b1;
    test_random_traffic(220, 1'b0);
    test_random_traffic(60, 1'b1);

    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d request words and checked %0d result words", words_sent,
             words_checked);
    $display("Covered %0d task runs and %0d dropped adds", runs_seen, drops_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** delta_queue_task_scheduler_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d result words never arrived", mismatches,
               pending_results.size());
      $display("** delta_queue_task_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

[delta_queue_task_scheduler_core.f]
design/dqts_pkg.sv
design/dqts_cell.sv
design/delta_queue_task_scheduler_core.sv
design/dqts_checker.sv
sim/tb_top.sv
